/* hdl/assert_macros.svh */
// Assertion macros used by the top level of the ELF hash block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

/* hdl/elfh_pkg.sv */
// Types, widths and the byte absorb function of the ELF hash block.
package elfh_pkg;

  localparam int HASH_W   = 28;
  localparam int BYTE_W   = 8;
  localparam int BUCKET_W = 16;

  typedef logic [HASH_W-1:0]   hash_t;
  typedef logic [BUCKET_W-1:0] bucket_t;

  typedef struct packed {
    logic [BYTE_W-1:0] key_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    hash_t   hash_value;
    bucket_t bucket_index;
  } out_item_t;

  function automatic hash_t absorb(input hash_t h, input logic [BYTE_W-1:0] b);
    logic [HASH_W+3:0] t;
    hash_t             r;
    t = {h, 4'h0} + {{(HASH_W-4){1'b0}}, b};
    r = t[HASH_W-1:0];
    r[7:4] = r[7:4] ^ t[HASH_W+3:HASH_W];
    return r;
  endfunction

endpackage

/* hdl/elfh_front.sv */
// Front end: takes key bytes, updates the running hash, queues finished hashes.
module elfh_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  elfh_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output elfh_pkg::hash_t   q_wdata
);
  import elfh_pkg::*;

  hash_t running_hash;
  hash_t hash_next;
  logic  accept;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign hash_next = absorb(running_hash, in_data.key_byte);
  assign q_push    = accept && in_data.last_byte;
  assign q_wdata   = hash_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
    end else if (accept) begin
      running_hash <= in_data.last_byte ? '0 : hash_next;
    end
  end

endmodule

/* hdl/elfh_fifo.sv */
// Short queue of finished key hashes between front and back end.
module elfh_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  elfh_pkg::hash_t wdata,
  input  logic            pop,
  output elfh_pkg::hash_t rdata,
  output logic            full,
  output logic            empty
);
  import elfh_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  hash_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/elfh_back.sv */
// Back end: bit-serial remainder of each hash by the bucket count, result register.
module elfh_back (
  input  logic               clk,
  input  logic               rst,
  input  elfh_pkg::bucket_t  bucket_count,
  input  logic               q_empty,
  input  elfh_pkg::hash_t    q_rdata,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output elfh_pkg::out_item_t out_data
);
  import elfh_pkg::*;

  localparam int CNT_W = $clog2(HASH_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(HASH_W - 1);

  typedef enum logic {IDLE, RUN} state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  hash_t            hash;
  hash_t            dvd;
  bucket_t          rem;
  bucket_t          div;
  bucket_t          rem_next;
  logic [BUCKET_W:0] r_ext;
  logic [BUCKET_W:0] r_sub;
  logic             out_free;
  logic             done;

  assign q_pop    = (state == IDLE) && !q_empty;
  assign out_free = !out_valid || !out_stall;
  assign done     = (state == RUN) && (cnt == '0) && out_free;

  always_comb begin
    r_ext    = {rem, dvd[HASH_W-1]};
    r_sub    = r_ext - {1'b0, div};
    rem_next = (r_ext >= {1'b0, div}) ? r_sub[BUCKET_W-1:0] : r_ext[BUCKET_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (!q_empty) begin
            hash  <= q_rdata;
            dvd   <= q_rdata;
            rem   <= '0;
            cnt   <= LAST_STEP;
            div   <= (bucket_count == '0) ? BUCKET_W'(1) : bucket_count;
            state <= RUN;
          end
        end
        RUN: begin
          if (cnt != '0) begin
            rem <= rem_next;
            dvd <= dvd << 1;
            cnt <= cnt - 1'b1;
          end else if (out_free) begin
            out_data.hash_value   <= hash;
            out_data.bucket_index <= rem_next;
            state                 <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* hdl/elf_hash_bucket_index.sv */
// Top level of the ELF hash and bucket index block.
//
//   channel | handshake          | item
//   --------+--------------------+-------------------------------------
//   in      | in_valid/in_stall  | key_byte, last_byte
//   out     | out_valid/out_stall| hash_value, bucket_index
//   cfg     | cfg_valid/cfg_ready| bucket_count write data
//
// Key bytes are absorbed one per cycle while the hash queue is not full;
// a key's final byte queues its hash. The back end loads each queued hash
// and runs it through a one-bit restoring divider, one key at a time.
// Reset clears the running hash, the queue and out_valid, but not out_data, and
// sets bucket_count to 1. in_stall rises only when the hash queue is full.
`include "assert_macros.svh"

module elf_hash_bucket_index #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  elfh_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output elfh_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  elfh_pkg::bucket_t   cfg_data
);
  import elfh_pkg::*;

  bucket_t bucket_count;
  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;
  hash_t   q_wdata;
  hash_t   q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      bucket_count <= cfg_data;
    end
  end

  elfh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  elfh_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  elfh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .bucket_count (bucket_count),
    .q_empty      (q_empty),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

  `ASSERT_CLK(a_bucket_in_range, clk, rst, out_valid |-> ((bucket_count == '0) ? (out_data.bucket_index == '0) : (out_data.bucket_index < bucket_count)))
  `ASSERT_CLK(a_last_byte_queued, clk, rst, (in_valid && !in_stall && in_data.last_byte) |=> !q_empty)
  `ASSERT_NEVER(a_pop_when_empty, clk, rst, q_pop && q_empty)

endmodule
